// ===== rtl/als_pkg.sv =====
// Package for the acceleration-limited angle slew block.
// Holds field widths, operation codes, register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package als_pkg;

  localparam int unsigned AngleW = 16;
  localparam int unsigned SpeedW = 24;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned SnapW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MulW   = 24;

  typedef enum logic {
    OP_TICK     = 1'b0,
    OP_RETARGET = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_SPEED     = 3'd0,
    REG_ACCELERATION  = 3'd1,
    REG_TOLERANCE     = 3'd2,
    REG_SNAP          = 3'd3,
    REG_BASE_ANGLE    = 3'd4,
    REG_TURRET_ENABLE = 3'd5,
    REG_FORCE_ENABLE  = 3'd6,
    REG_FORCED_ANGLE  = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VV,
    S_LHS_LO,
    S_LHS_HI,
    S_AD,
    S_X_LO,
    S_X_HI,
    S_Y,
    S_DECIDE,
    S_STEP,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/als_mul.sv =====
// Shared unsigned multiplier used by every product of one tick.
// Depends on als_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none

module als_mul (
  input  wire logic [als_pkg::MulW-1:0]   a_i,
  input  wire logic [als_pkg::MulW-1:0]   b_i,
  output logic      [2*als_pkg::MulW-1:0] p_o
);

  assign p_o = {{als_pkg::MulW{1'b0}}, a_i} * {{als_pkg::MulW{1'b0}}, b_i};

endmodule

`default_nettype wire

// ===== rtl/accel_limited_angle_slew.sv =====
// Top level of the acceleration-limited angle slew block.
// Depends on als_pkg and als_mul.
//
// One item at a time: a tick with motion runs a sequencer from transfer to result
// (eight products through one shared 24x24 multiplier, then the speed update and
// step; a tick that snaps onto the target skips the step), while a retarget or a
// tick while disabled goes straight to the output state. A new item is taken once
// the previous result has been transferred.
// Configuration writes are always ready and must only occur while idle.
`timescale 1ns / 1ps
`default_nettype none

module accel_limited_angle_slew (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [als_pkg::AngleW-1:0]  target_angle_i,
  input  wire logic                        target_valid_i,
  input  wire logic [als_pkg::TimeW-1:0]   elapsed_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [als_pkg::AngleW-1:0]  current_angle_o,
  output logic      [als_pkg::SpeedW-1:0]  speed_o,
  output logic                             aligned_o,
  output logic                             at_base_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [als_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [als_pkg::SpeedW-1:0]  cfg_data_i
);

  als_pkg::state_e state_q, state_d;

  logic [23:0] max_speed_q, accel_q;
  logic [15:0] tol_q, base_q, forced_q;
  logic [7:0]  snap_q;
  logic        en_q, force_q;

  logic [15:0] angle_q, err_q;
  logic [23:0] speed_q;

  logic [15:0] tgt_q, dt_q, e_q;
  logic [47:0] vv_q;
  logic [63:0] lhs_q;
  logic [39:0] ad_q;
  logic [55:0] x_q;
  logic [64:0] rhs_q;

  logic        out_valid_q;
  logic [15:0] out_angle_q;
  logic [23:0] out_speed_q;
  logic        out_aligned_q, out_base_q;

  logic [23:0] mul_a, mul_b;
  logic [47:0] prod;

  logic        accept;
  logic [15:0] sel_tgt, fresh, fresh_mag, err_mag, base_mag, base_delta;
  logic        acc;
  logic [27:0] inc;
  logic [28:0] nv_w;
  logic [23:0] nv;
  logic [19:0] step20;
  logic [15:0] stp;

  als_mul u_mul (.a_i(mul_a), .b_i(mul_b), .p_o(prod));

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != als_pkg::S_IDLE) || out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;

  assign sel_tgt   = force_q ? forced_q : (target_valid_i ? target_angle_i : base_q);
  assign fresh     = tgt_q - angle_q;
  assign fresh_mag = fresh[15] ? 16'(-fresh) : fresh;
  assign err_mag   = err_q[15] ? 16'(-err_q) : err_q;
  assign base_delta = base_q - angle_q;
  assign base_mag  = base_delta[15] ? 16'(-base_delta) : base_delta;

  assign acc  = rhs_q[64] || (lhs_q < rhs_q[63:0]);
  assign inc  = ad_q[39:12];
  always_comb begin
    if (acc) begin
      nv_w = {5'b0, speed_q} + {1'b0, inc};
    end else if ({4'b0, speed_q} >= inc) begin
      nv_w = 29'({4'b0, speed_q} - inc);
    end else begin
      nv_w = '0;
    end
  end
  assign nv = (nv_w > {5'b0, max_speed_q}) ? max_speed_q : nv_w[23:0];

  assign step20 = prod[39:20];
  assign stp    = (step20 > {4'b0, err_mag}) ? err_mag : step20[15:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      als_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (en_q && operation_i == als_pkg::OP_TICK) ? als_pkg::S_VV
                                                              : als_pkg::S_OUT;
        end
      end
      als_pkg::S_VV:     state_d = als_pkg::S_LHS_LO;
      als_pkg::S_LHS_LO: state_d = als_pkg::S_LHS_HI;
      als_pkg::S_LHS_HI: state_d = als_pkg::S_AD;
      als_pkg::S_AD:     state_d = als_pkg::S_X_LO;
      als_pkg::S_X_LO:   state_d = als_pkg::S_X_HI;
      als_pkg::S_X_HI:   state_d = als_pkg::S_Y;
      als_pkg::S_Y:      state_d = als_pkg::S_DECIDE;
      als_pkg::S_DECIDE: begin
        state_d = (fresh_mag < {8'b0, snap_q}) ? als_pkg::S_OUT : als_pkg::S_STEP;
      end
      als_pkg::S_STEP:   state_d = als_pkg::S_OUT;
      als_pkg::S_OUT:    state_d = als_pkg::S_IDLE;
      default:           state_d = als_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_a = speed_q;
    mul_b = speed_q;
    unique case (state_q)
      als_pkg::S_LHS_LO: begin mul_a = vv_q[23:0];  mul_b = {8'b0, dt_q}; end
      als_pkg::S_LHS_HI: begin mul_a = vv_q[47:24]; mul_b = {8'b0, dt_q}; end
      als_pkg::S_AD:     begin mul_a = accel_q;     mul_b = {8'b0, dt_q}; end
      als_pkg::S_X_LO:   begin mul_a = ad_q[23:0];  mul_b = {8'b0, e_q};  end
      als_pkg::S_X_HI:   begin mul_a = {8'b0, ad_q[39:24]}; mul_b = {8'b0, e_q}; end
      als_pkg::S_Y:      begin mul_a = speed_q;     mul_b = {8'b0, e_q};  end
      als_pkg::S_STEP:   begin mul_a = speed_q;     mul_b = {8'b0, dt_q}; end
      default: begin
        mul_a = speed_q;
        mul_b = speed_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= als_pkg::S_IDLE;
      max_speed_q <= '0;
      accel_q     <= '0;
      tol_q       <= '0;
      snap_q      <= 8'd1;
      base_q      <= '0;
      en_q        <= 1'b0;
      force_q     <= 1'b0;
      forced_q    <= '0;
      angle_q     <= '0;
      speed_q     <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (als_pkg::reg_idx_e'(cfg_index_i))
          als_pkg::REG_MAX_SPEED:     max_speed_q <= cfg_data_i;
          als_pkg::REG_ACCELERATION:  accel_q     <= cfg_data_i;
          als_pkg::REG_TOLERANCE:     tol_q       <= cfg_data_i[15:0];
          als_pkg::REG_SNAP:          snap_q      <= cfg_data_i[7:0];
          als_pkg::REG_BASE_ANGLE: begin
            base_q  <= cfg_data_i[15:0];
            angle_q <= cfg_data_i[15:0];
          end
          als_pkg::REG_TURRET_ENABLE: en_q        <= cfg_data_i[0];
          als_pkg::REG_FORCE_ENABLE:  force_q     <= cfg_data_i[0];
          als_pkg::REG_FORCED_ANGLE:  forced_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        als_pkg::S_IDLE: begin
          if (accept && en_q && operation_i == als_pkg::OP_RETARGET) begin
            err_q <= sel_tgt - angle_q;
          end
        end
        als_pkg::S_DECIDE: begin
          if (fresh_mag < {8'b0, snap_q}) begin
            angle_q <= tgt_q;
            err_q   <= '0;
            speed_q <= '0;
          end else begin
            speed_q <= nv;
            err_q   <= fresh;
          end
        end
        als_pkg::S_STEP: begin
          if (!err_q[15]) begin
            angle_q <= angle_q + stp;
            err_q   <= err_q - stp;
          end else begin
            angle_q <= angle_q - stp;
            err_q   <= err_q + stp;
          end
        end
        als_pkg::S_OUT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tgt_q <= sel_tgt;
      dt_q  <= elapsed_i;
      e_q   <= err_mag;
    end
    unique case (state_q)
      als_pkg::S_VV:     vv_q  <= prod;
      als_pkg::S_LHS_LO: lhs_q <= {24'b0, prod[39:0]};
      als_pkg::S_LHS_HI: lhs_q <= {24'b0, lhs_q[39:0]} + {prod[39:0], 24'b0};
      als_pkg::S_AD:     ad_q  <= prod[39:0];
      als_pkg::S_X_LO:   x_q   <= {16'b0, prod[39:0]};
      als_pkg::S_X_HI:   x_q   <= {16'b0, x_q[39:0]} + {prod[31:0], 24'b0};
      als_pkg::S_Y:      rhs_q <= {x_q, 9'b0} + {4'b0, prod[39:0], 21'b0};
      als_pkg::S_OUT: begin
        out_angle_q   <= angle_q;
        out_speed_q   <= speed_q;
        out_aligned_q <= err_mag < tol_q;
        out_base_q    <= base_mag < {8'b0, snap_q};
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign current_angle_o = out_angle_q;
  assign speed_o         = out_speed_q;
  assign aligned_o       = out_aligned_q;
  assign at_base_o       = out_base_q;

endmodule

`default_nettype wire

// ===== tb/tb_accel_limited_angle_slew.sv =====
// Self-checking testbench for the acceleration-limited angle slew block.
// Depends on als_pkg and accel_limited_angle_slew; predicts every result in-bench.
`timescale 1ns / 1ps

module tb_accel_limited_angle_slew;

  localparam int   IDLE_LIMIT  = 20000;
  localparam int   HOLD_CYCLES = 1500;

  typedef struct packed {
    logic [als_pkg::AngleW-1:0] angle;
    logic [als_pkg::SpeedW-1:0] speed;
    logic                       aligned;
    logic                       at_base;
  } slew_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         operation_i;
  logic [als_pkg::AngleW-1:0]   target_angle_i;
  logic                         target_valid_i;
  logic [als_pkg::TimeW-1:0]    elapsed_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [als_pkg::AngleW-1:0]   current_angle_o;
  logic [als_pkg::SpeedW-1:0]   speed_o;
  logic                         aligned_o;
  logic                         at_base_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [als_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [als_pkg::SpeedW-1:0]   cfg_data_i;

  accel_limited_angle_slew dut (.*);

  // shadow configuration and axis state
  logic [als_pkg::SpeedW-1:0] max_spd, accel_rate;
  logic [15:0]                tol;
  logic [als_pkg::SnapW-1:0]  snap;
  logic [als_pkg::AngleW-1:0] base, forced;
  logic                       axis_en, force_en;
  logic [als_pkg::AngleW-1:0] axis_angle;
  logic [als_pkg::SpeedW-1:0] axis_speed;
  int                         angle_err;

  slew_result_t expected_q[$];
  bit           failed;
  int           send_idle_pct;
  int           stall_pct;
  bit           holdoff_req;
  int           quiet_cycles;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic int short_delta(logic [als_pkg::AngleW-1:0] to,
                                     logic [als_pkg::AngleW-1:0] from);
    logic [als_pkg::AngleW-1:0] d;
    d = to - from;
    return d[15] ? int'(d) - 65536 : int'(d);
  endfunction

  function automatic int magn(int e);
    return e < 0 ? -e : e;
  endfunction

  function automatic slew_result_t predict_slew(logic op, logic [als_pkg::AngleW-1:0] tgt,
                                                logic tv, logic [als_pkg::TimeW-1:0] dt);
    logic [als_pkg::AngleW-1:0] target;
    int                         fresh;
    logic [65:0]                lhs, rhs, e_prev;
    logic [47:0]                inc, nv;
    logic [47:0]                st;
    slew_result_t               r;
    if (axis_en) begin
      target = force_en ? forced : (tv ? tgt : base);
      fresh  = short_delta(target, axis_angle);
      if (op == als_pkg::OP_RETARGET) begin
        angle_err = fresh;
      end else begin
        e_prev = 66'(magn(angle_err));
        lhs = 66'(axis_speed) * 66'(axis_speed) * 66'(dt);
        rhs = ((66'(accel_rate) * 66'(dt) * e_prev) << 9) + ((66'(axis_speed) * e_prev) << 21);
        inc = (48'(accel_rate) * 48'(dt)) >> 12;
        if (lhs < rhs) nv = 48'(axis_speed) + inc;
        else nv = (48'(axis_speed) >= inc) ? 48'(axis_speed) - inc : 48'd0;
        if (nv > 48'(max_spd)) nv = 48'(max_spd);
        axis_speed = nv[als_pkg::SpeedW-1:0];
        angle_err  = fresh;
        if (magn(angle_err) < int'(snap)) begin
          axis_angle = target;
          angle_err  = 0;
          axis_speed = '0;
        end else begin
          st = (48'(dt) * 48'(axis_speed)) >> 20;
          if (st > 48'(magn(angle_err))) st = 48'(magn(angle_err));
          if (angle_err > 0) begin
            axis_angle = axis_angle + st[15:0];
            angle_err  = angle_err - int'(st);
          end else begin
            axis_angle = axis_angle - st[15:0];
            angle_err  = angle_err + int'(st);
          end
        end
      end
    end
    r.angle   = axis_angle;
    r.speed   = axis_speed;
    r.aligned = magn(angle_err) < int'(tol);
    r.at_base = magn(short_delta(base, axis_angle)) < int'(snap);
    return r;
  endfunction

  task automatic send_item(logic op, logic [als_pkg::AngleW-1:0] tgt, logic tv,
                           logic [als_pkg::TimeW-1:0] dt);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     = 1'b1;
    operation_i    = op;
    target_angle_i = tgt;
    target_valid_i = tv;
    elapsed_i      = dt;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(predict_slew(op, tgt, tv, dt));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (expected_q.size() == 0);
    repeat (15) @(negedge clk_i);
  endtask

  task automatic cfg_write(als_pkg::reg_idx_e idx, logic [als_pkg::SpeedW-1:0] data);
    drain();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      als_pkg::REG_MAX_SPEED:     max_spd = data;
      als_pkg::REG_ACCELERATION:  accel_rate = data;
      als_pkg::REG_TOLERANCE:     tol = data[15:0];
      als_pkg::REG_SNAP:          snap = data[als_pkg::SnapW-1:0];
      als_pkg::REG_BASE_ANGLE: begin
        base       = data[als_pkg::AngleW-1:0];
        axis_angle = data[als_pkg::AngleW-1:0];
      end
      als_pkg::REG_TURRET_ENABLE: axis_en = data[0];
      als_pkg::REG_FORCE_ENABLE:  force_en = data[0];
      als_pkg::REG_FORCED_ANGLE:  forced = data[als_pkg::AngleW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [als_pkg::TimeW-1:0] rand_dt();
    return ($urandom_range(9) == 0) ? als_pkg::TimeW'($urandom_range(65535, 1))
                                    : als_pkg::TimeW'($urandom_range(4096, 1));
  endfunction

  task automatic test_frozen_after_reset();
    send_item(als_pkg::OP_TICK, 16'h4000, 1'b1, 16'd4096);
    send_item(als_pkg::OP_RETARGET, 16'hFFFF, 1'b1, 16'd1);
    send_item(als_pkg::OP_TICK, 16'h0000, 1'b0, 16'hFFFF);
  endtask

  task automatic test_directed();
    cfg_write(als_pkg::REG_MAX_SPEED, 24'hFFFFFF);
    cfg_write(als_pkg::REG_ACCELERATION, 24'hFFFFFF);
    cfg_write(als_pkg::REG_TOLERANCE, 24'd32768);
    cfg_write(als_pkg::REG_SNAP, 24'd255);
    cfg_write(als_pkg::REG_BASE_ANGLE, 24'h8000);
    cfg_write(als_pkg::REG_FORCED_ANGLE, 24'h1234);
    cfg_write(als_pkg::REG_TURRET_ENABLE, 24'd1);
    send_item(als_pkg::OP_RETARGET, 16'h0000, 1'b1, 16'd1);
    send_item(als_pkg::OP_TICK, 16'h0000, 1'b1, 16'd1);
    send_item(als_pkg::OP_TICK, 16'h0000, 1'b1, 16'hFFFF);
    send_item(als_pkg::OP_TICK, 16'hFFFF, 1'b1, 16'd100);
    send_item(als_pkg::OP_TICK, 16'h0000, 1'b0, 16'd4096);
    send_item(als_pkg::OP_TICK, 16'h80FF, 1'b1, 16'd2);
    cfg_write(als_pkg::REG_FORCE_ENABLE, 24'd1);
    send_item(als_pkg::OP_RETARGET, 16'hAAAA, 1'b1, 16'd1);
    send_item(als_pkg::OP_TICK, 16'h5555, 1'b1, 16'd300);
    send_item(als_pkg::OP_TICK, 16'h5555, 1'b0, 16'd300);
    cfg_write(als_pkg::REG_FORCE_ENABLE, 24'd0);
    cfg_write(als_pkg::REG_SNAP, 24'd0);
    cfg_write(als_pkg::REG_MAX_SPEED, 24'h010000);
    cfg_write(als_pkg::REG_ACCELERATION, 24'h004000);
    send_item(als_pkg::OP_TICK, 16'h0100, 1'b1, 16'd4096);
    send_item(als_pkg::OP_TICK, 16'h0100, 1'b1, 16'd4096);
    send_item(als_pkg::OP_TICK, 16'h0100, 1'b1, 16'd8192);
    cfg_write(als_pkg::REG_ACCELERATION, 24'd0);
    send_item(als_pkg::OP_TICK, 16'h0100, 1'b1, 16'd4096);
    cfg_write(als_pkg::REG_TURRET_ENABLE, 24'd0);
    send_item(als_pkg::OP_TICK, 16'h7000, 1'b1, 16'd4096);
    send_item(als_pkg::OP_RETARGET, 16'h7000, 1'b1, 16'd4096);
  endtask

  task automatic randomize_config(int k);
    cfg_write(als_pkg::REG_MAX_SPEED,
              (k % 4 == 0) ? 24'hFFFFFF : 24'($urandom_range(24'h200000)));
    cfg_write(als_pkg::REG_ACCELERATION, (k % 5 == 1) ? 24'd0 :
              (k % 5 == 2) ? 24'hFFFFFF : 24'($urandom_range(24'h100000)));
    cfg_write(als_pkg::REG_TOLERANCE, (k % 3 == 0) ? 24'd32768 : 24'($urandom_range(4000)));
    cfg_write(als_pkg::REG_SNAP, (k % 4 == 3) ? 24'd255 : 24'($urandom_range(40)));
    cfg_write(als_pkg::REG_BASE_ANGLE, 24'($urandom_range(65535)));
    cfg_write(als_pkg::REG_FORCED_ANGLE, 24'($urandom_range(65535)));
    cfg_write(als_pkg::REG_FORCE_ENABLE, 24'($urandom_range(5) == 0));
    cfg_write(als_pkg::REG_TURRET_ENABLE, 24'($urandom_range(7) != 0));
  endtask

  task automatic test_random_slews(int count, int k);
    logic [als_pkg::AngleW-1:0] tgt;
    logic                       tv;
    int                         run;
    randomize_config(k);
    run = 0;
    for (int i = 0; i < count; i++) begin
      if (run == 0) begin
        tgt = als_pkg::AngleW'($urandom_range(65535));
        tv  = $urandom_range(5) != 0;
        run = $urandom_range(40, 3);
        send_item(als_pkg::OP_RETARGET, tgt, tv, rand_dt());
      end else if ($urandom_range(19) == 0) begin
        send_item(logic'($urandom_range(1)), als_pkg::AngleW'($urandom_range(65535)),
                  logic'($urandom_range(1)), rand_dt());
      end else begin
        send_item(als_pkg::OP_TICK, tgt, tv, rand_dt());
      end
      run--;
      if (i % 100 == 99) randomize_config(k + i);
    end
  endtask

  task automatic test_backpressure();
    randomize_config(0);
    cfg_write(als_pkg::REG_TURRET_ENABLE, 24'd1);
    holdoff_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_item(als_pkg::OP_TICK, 16'h3000, 1'b1, rand_dt());
  endtask

  // receiver
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    slew_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result angle %h speed %h", current_angle_o, speed_o);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (current_angle_o !== e.angle) begin
          $error("current_angle expected %h actual %h", e.angle, current_angle_o);
          failed = 1'b1;
        end
        if (speed_o !== e.speed) begin
          $error("speed expected %h actual %h", e.speed, speed_o);
          failed = 1'b1;
        end
        if (aligned_o !== e.aligned) begin
          $error("aligned expected %b actual %b", e.aligned, aligned_o);
          failed = 1'b1;
        end
        if (at_base_o !== e.at_base) begin
          $error("at_base expected %b actual %b", e.at_base, at_base_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = als_pkg::OP_TICK;
    target_angle_i = '0;
    target_valid_i = 1'b0;
    elapsed_i = 16'd1;
    cfg_valid_i = 1'b0;
    cfg_index_i = als_pkg::REG_MAX_SPEED;
    cfg_data_i = '0;
    failed = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    holdoff_req = 1'b0;
    quiet_cycles = 0;
    max_spd = '0; accel_rate = '0; tol = '0; snap = 8'd1;
    base = '0; forced = '0; axis_en = 1'b0; force_en = 1'b0;
    axis_angle = '0; axis_speed = '0; angle_err = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_frozen_after_reset();
    test_directed();
    send_idle_pct = 0;  stall_pct = 0;  test_random_slews(400, 0);
    send_idle_pct = 85; stall_pct = 0;  test_random_slews(400, 1);
    send_idle_pct = 0;  stall_pct = 85; test_random_slews(400, 2);
    send_idle_pct = 34; stall_pct = 34; test_random_slews(400, 3);
    send_idle_pct = 0;  stall_pct = 0;  test_backpressure();

    drain();
    repeat (30) @(posedge clk_i);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
